>>> rtl/core/gtr_pkg.sv
// Shared types, register map and the 5x7 font table for the glyph rectangle renderer.
// Used by gtr_font_rom and glyph_text_rect_renderer.
package gtr_pkg;

    localparam int CoordW   = 16;
    localparam int ScaleW   = 8;
    localparam int GlyphW   = 35;   // 5 columns x 7 bits, column 0 in the low bits
    localparam int GlyphCol = 5;
    localparam int GlyphRow = 7;
    localparam int LetterN  = 26;
    localparam int AddrW    = 4;

    // register indexes
    localparam logic [1:0] RegScale  = 2'd0;
    localparam logic [1:0] RegColor  = 2'd1;
    localparam logic [1:0] RegWidth  = 2'd2;
    localparam logic [1:0] RegHeight = 2'd3;

    localparam logic [7:0] CharNewline = 8'd10;
    localparam logic [7:0] CharA       = 8'd65;
    localparam logic [7:0] CharZ       = 8'd90;

    typedef logic [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t     x_left;
        coord_t     y_top;
        coord_t     x_right;
        coord_t     y_bottom;
    } rect_t;

    typedef logic [GlyphRow-1:0] font_col_t;

    localparam font_col_t FontCols [LetterN][GlyphCol] = '{
        '{7'h3F, 7'h44, 7'h44, 7'h44, 7'h3F}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
        '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h48, 7'h48, 7'h48, 7'h40},
        '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h2E}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
        '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h02, 7'h01, 7'h41, 7'h7E, 7'h40},
        '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h01, 7'h01, 7'h01, 7'h01},
        '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F}, '{7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h48, 7'h48, 7'h48, 7'h30},
        '{7'h3E, 7'h41, 7'h45, 7'h42, 7'h25}, '{7'h7F, 7'h48, 7'h4C, 7'h4A, 7'h31},
        '{7'h31, 7'h49, 7'h49, 7'h49, 7'h46}, '{7'h40, 7'h40, 7'h7F, 7'h40, 7'h40},
        '{7'h7E, 7'h01, 7'h01, 7'h01, 7'h7E}, '{7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C},
        '{7'h7E, 7'h01, 7'h0E, 7'h01, 7'h7E}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        '{7'h70, 7'h08, 7'h07, 7'h08, 7'h70}, '{7'h43, 7'h45, 7'h49, 7'h51, 7'h61}
    };

    // Whole glyph as one word; codes past Z give an empty glyph.
    function automatic logic [GlyphW-1:0] glyph_lookup(input logic [4:0] idx);
        logic [GlyphW-1:0] g;
        g = '0;
        if (idx < 5'(LetterN)) begin
            g = {FontCols[idx][4], FontCols[idx][3], FontCols[idx][2],
                 FontCols[idx][1], FontCols[idx][0]};
        end
        return g;
    endfunction

endpackage

>>> rtl/core/gtr_font_rom.sv
// Synchronous font ROM: registered glyph word and letter flag, valid in the cycle after rd_en.
// Depends on gtr_pkg for the font table.
module gtr_font_rom
    import gtr_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [7:0]        char_code,
    output logic [GlyphW-1:0] glyph_bits,
    output logic              is_letter
);

    logic [7:0]        letter_idx;
    logic              letter_hit;
    logic [GlyphW-1:0] glyph_reg;
    logic              letter_reg;

    assign letter_idx = char_code - CharA;
    assign letter_hit = (char_code >= CharA) && (char_code <= CharZ);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            glyph_reg  <= glyph_lookup(letter_idx[4:0]);
            letter_reg <= letter_hit;
        end
    end

    assign glyph_bits = glyph_reg;
    assign is_letter  = letter_reg;

endmodule

>>> rtl/core/glyph_text_rect_renderer.sv
// Top level of the scaled 5x7 text rectangle renderer.
// Depends on gtr_pkg and gtr_font_rom; cursor and baseline live in a one-word state memory.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  char_code, base_x, base_y; tuser first_of_string
//  m_*       out        m_tvalid / m_tready  x_left, y_top, x_right, y_bottom, color; tlast
//  p*        config     psel & penable       scale, fill_color, screen_width, screen_height
//
// A letter goes through the state memory and font ROM read, the load step, the scan loop at one
// font bit per cycle unless stalled, then a flush and state write-back. Newline and other
// codes finish in the load step. A found square waits in a one-deep hold register until the next
// hit or the end of the glyph decides its last flag; the scan stalls only while a hit finds the
// hold register full and the output register full and not taken. Reset is synchronous; no clearing pass is needed.
module glyph_text_rect_renderer
    import gtr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // input requests
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // char_code[7:0], base_x[23:8], base_y[39:24]
    input  logic             s_tuser,   // first_of_string
    // result requests
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [79:0]      m_tdata,   // x_left, y_top, x_right, y_bottom, color
    output logic             m_tlast,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StLoad  = 3'd1;
    localparam logic [2:0] StScan  = 3'd2;
    localparam logic [2:0] StFlush = 3'd3;

    // configuration
    logic [ScaleW-1:0] scale_reg;
    coord_t            color_reg;
    coord_t            width_reg;
    coord_t            height_reg;
    logic              cfg_we;
    logic [1:0]        cfg_idx;

    // state memory: {row_baseline, column_cursor}
    logic [2*CoordW-1:0] state_mem [1];
    logic [2*CoordW-1:0] st_rdata_reg;
    logic                st_valid_reg;
    logic                st_we;
    logic [2*CoordW-1:0] st_wdata;

    logic [2:0]        fsm_reg, fsm_next;
    logic              in_accept;
    logic [7:0]        char_reg;
    logic              first_reg;
    coord_t            bx_reg;
    coord_t            by_reg;
    logic [GlyphW-1:0] glyph_bits;
    logic              is_letter;

    // scan registers
    logic [GlyphW-1:0] glyph_sh_reg, glyph_sh_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    coord_t            cursor_reg, cursor_next;
    coord_t            base_reg, base_next;
    coord_t            xl_reg, xl_next;
    coord_t            yt_reg, yt_next;
    coord_t            yb_reg, yb_next;

    // hold and output registers
    rect_t             pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    rect_t             out_reg, out_next;
    logic              out_last_reg, out_last_next;
    coord_t            out_color_reg, out_color_next;
    logic              out_valid_reg, out_valid_next;

    coord_t            scale16;
    coord_t            cursor0, base0;
    coord_t            xr_cur;
    logic              hit;
    logic              out_busy;
    logic              advance;
    rect_t             cur_rect;

    assign scale16   = {{(CoordW-ScaleW){1'b0}}, scale_reg};
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (fsm_reg == StIdle);
    assign out_busy  = out_valid_reg && !m_tready;

    // ---------------- configuration port ----------------
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= ScaleW'(1);
            color_reg  <= 16'hFFFF;
            width_reg  <= 16'd240;
            height_reg <= 16'd320;
        end else if (cfg_we) begin
            case (cfg_idx)
                RegScale:  scale_reg  <= pwdata[ScaleW-1:0];
                RegColor:  color_reg  <= pwdata[CoordW-1:0];
                RegWidth:  width_reg  <= pwdata[CoordW-1:0];
                RegHeight: height_reg <= pwdata[CoordW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            RegScale:  prdata = {{(32-ScaleW){1'b0}}, scale_reg};
            RegColor:  prdata = {16'd0, color_reg};
            RegWidth:  prdata = {16'd0, width_reg};
            RegHeight: prdata = {16'd0, height_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------- input capture and font ROM ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            char_reg  <= s_tdata[7:0];
            bx_reg    <= s_tdata[23:8];
            by_reg    <= s_tdata[39:24];
            first_reg <= s_tuser;
        end
    end

    gtr_font_rom u_font (
        .aclk       (aclk),
        .rd_en      (in_accept),
        .char_code  (s_tdata[7:0]),
        .glyph_bits (glyph_bits),
        .is_letter  (is_letter)
    );

    // ---------------- state memory ----------------
    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[0] <= st_wdata;
        end
        if (in_accept) begin
            st_rdata_reg <= st_valid_reg ? state_mem[0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (st_we) begin
            st_valid_reg <= 1'b1;
        end
    end

    // ---------------- scan datapath ----------------
    assign cursor0  = first_reg ? '0 : st_rdata_reg[CoordW-1:0];
    assign base0    = first_reg ? by_reg : st_rdata_reg[2*CoordW-1:CoordW];
    assign xr_cur   = xl_reg + scale16 - 16'd1;
    assign hit      = glyph_sh_reg[0] && (xl_reg <= xr_cur) && (yt_reg <= yb_reg)
                      && (xr_cur < width_reg) && (yb_reg < height_reg);
    assign cur_rect = '{x_left: xl_reg, y_top: yt_reg, x_right: xr_cur, y_bottom: yb_reg};
    // stall the scan while a hit would need to push the held square into a full output
    assign advance  = !(hit && pend_valid_reg && out_busy);

    always_comb begin
        fsm_next        = fsm_reg;
        glyph_sh_next   = glyph_sh_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cursor_next     = cursor_reg;
        base_next       = base_reg;
        xl_next         = xl_reg;
        yt_next         = yt_reg;
        yb_next         = yb_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_color_next  = out_color_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        st_we           = 1'b0;
        st_wdata        = {base0, cursor0};

        case (fsm_reg)
            StIdle: begin
                if (in_accept) begin
                    fsm_next = StLoad;
                end
            end
            StLoad: begin
                cursor_next   = cursor0;
                base_next     = base0;
                glyph_sh_next = glyph_bits;
                col_next      = '0;
                row_next      = '0;
                xl_next       = bx_reg + cursor0;
                yt_next       = base0 - scale16;
                yb_next       = base0 - 16'd1;
                if (char_reg == CharNewline) begin
                    st_we    = 1'b1;
                    st_wdata = {base0 + {scale16[CoordW-4:0], 3'b000}, 16'd0};
                    fsm_next = StIdle;
                end else if (!is_letter) begin
                    st_we    = 1'b1;
                    st_wdata = {base0, cursor0 + {scale16[CoordW-3:0], 2'b00}
                                               + {scale16[CoordW-2:0], 1'b0}};
                    fsm_next = StIdle;
                end else begin
                    fsm_next = StScan;
                end
            end
            StScan: begin
                if (advance) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_color_next = color_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = cur_rect;
                        pend_valid_next = 1'b1;
                    end
                    glyph_sh_next = glyph_sh_reg >> 1;
                    if (row_reg == 3'(GlyphRow - 1)) begin
                        row_next = '0;
                        col_next = col_reg + 3'd1;
                        xl_next  = xl_reg + scale16;
                        yt_next  = base_reg - scale16;
                        yb_next  = base_reg - 16'd1;
                        if (col_reg == 3'(GlyphCol - 1)) begin
                            fsm_next = StFlush;
                        end
                    end else begin
                        row_next = row_reg + 3'd1;
                        yt_next  = yt_reg - scale16;
                        yb_next  = yb_reg - scale16;
                    end
                end
            end
            StFlush: begin
                if (!(pend_valid_reg && out_busy)) begin
                    if (pend_valid_reg) begin
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        out_color_next  = color_reg;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    st_we    = 1'b1;
                    st_wdata = {base_reg, cursor_reg + {scale16[CoordW-3:0], 2'b00}
                                                     + {scale16[CoordW-2:0], 1'b0}};
                    fsm_next = StIdle;
                end
            end
            default: begin
                fsm_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= StIdle;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        glyph_sh_reg  <= glyph_sh_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        cursor_reg    <= cursor_next;
        base_reg      <= base_next;
        xl_reg        <= xl_next;
        yt_reg        <= yt_next;
        yb_reg        <= yb_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
        out_color_reg <= out_color_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_reg.y_bottom, out_reg.x_right,
                       out_reg.y_top, out_reg.x_left};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    // the hold register is empty whenever a new character may enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("held square left over at character boundary");

    // state write-back happens only when a character finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |-> (fsm_reg == StLoad || fsm_reg == StFlush))
        else $error("state memory written outside load or flush");

    // the scan only leaves toward the flush step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == StScan) |=> (fsm_reg == StScan || fsm_reg == StFlush))
        else $error("scan left without flush");

    // the flush waits while a held square faces a full output register with a stalled sink
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == StFlush && pend_valid_reg && out_busy) |=> (fsm_reg == StFlush))
        else $error("flush finished while output was blocked");
`endif

endmodule

>>> tb/glyph_text_rect_renderer_checker.sv
`timescale 1ns / 100ps
// Checker for glyph_text_rect_renderer: snoops the input, result and register ports,
// predicts each square the renderer has to emit and compares them in arrival order.
// Depends on gtr_pkg for coordinate type, register indexes and character codes.
module glyph_text_rect_renderer_checker
    import gtr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [39:0]      s_tdata,   // char_code[7:0], base_x[23:8], base_y[39:24]
    input  logic             s_tuser,   // first_of_string
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [79:0]      m_tdata,   // x_left, y_top, x_right, y_bottom, color
    input  logic             m_tlast,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               mismatches,
    output int               squares_pending
);

    typedef struct packed {
        coord_t x_left;
        coord_t y_top;
        coord_t x_right;
        coord_t y_bottom;
        coord_t color;
        logic   last;
    } square_t;

    // column-wise dot patterns, bit 0 is the lowest dot row above the baseline
    localparam logic [6:0] LetterDots [26][5] = '{
        '{7'h3F, 7'h44, 7'h44, 7'h44, 7'h3F}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
        '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h48, 7'h48, 7'h48, 7'h40},
        '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h2E}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
        '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h02, 7'h01, 7'h41, 7'h7E, 7'h40},
        '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h01, 7'h01, 7'h01, 7'h01},
        '{7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F}, '{7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h48, 7'h48, 7'h48, 7'h30},
        '{7'h3E, 7'h41, 7'h45, 7'h42, 7'h25}, '{7'h7F, 7'h48, 7'h4C, 7'h4A, 7'h31},
        '{7'h31, 7'h49, 7'h49, 7'h49, 7'h46}, '{7'h40, 7'h40, 7'h7F, 7'h40, 7'h40},
        '{7'h7E, 7'h01, 7'h01, 7'h01, 7'h7E}, '{7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C},
        '{7'h7E, 7'h01, 7'h0E, 7'h01, 7'h7E}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        '{7'h70, 7'h08, 7'h07, 7'h08, 7'h70}, '{7'h43, 7'h45, 7'h49, 7'h51, 7'h61}
    };

    logic [7:0] dot_size;
    coord_t     fill;
    coord_t     span_x;
    coord_t     span_y;
    coord_t     pen_x;
    coord_t     pen_row;
    square_t    squares_due [$];

    task automatic report_mismatch(input string what);
        $display("[checker] mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_square(input logic [79:0] data, input logic tl);
        square_t got;
        square_t want;
        got.x_left   = data[15:0];
        got.y_top    = data[31:16];
        got.x_right  = data[47:32];
        got.y_bottom = data[63:48];
        got.color    = data[79:64];
        got.last     = tl;
        if (squares_due.size() == 0) begin
            report_mismatch($sformatf("unexpected square %p", got));
        end else begin
            want = squares_due.pop_front();
            if (got.x_left !== want.x_left)
                report_mismatch($sformatf("x_left %0d, want %0d", got.x_left, want.x_left));
            if (got.y_top !== want.y_top)
                report_mismatch($sformatf("y_top %0d, want %0d", got.y_top, want.y_top));
            if (got.x_right !== want.x_right)
                report_mismatch($sformatf("x_right %0d, want %0d", got.x_right, want.x_right));
            if (got.y_bottom !== want.y_bottom)
                report_mismatch($sformatf("y_bottom %0d, want %0d", got.y_bottom,
                                          want.y_bottom));
            if (got.color !== want.color)
                report_mismatch($sformatf("color %h, want %h", got.color, want.color));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
    endtask

    // Walk the glyph column by column, dot by dot, and queue every square that survives
    // the screen clip; the last one of the character is held back to get its last flag.
    task automatic render_char(input logic [39:0] data, input logic first);
        logic [7:0] code;
        coord_t     org_x;
        coord_t     xl;
        coord_t     xr;
        coord_t     yt;
        coord_t     yb;
        logic [6:0] dots;
        square_t    held;
        logic       have_held;
        int         j;
        int         k;
        code      = data[7:0];
        have_held = 1'b0;
        held      = '0;
        if (first) begin
            pen_x   = '0;
            pen_row = data[39:24];
        end
        if (code == CharNewline) begin
            pen_x   = '0;
            pen_row = pen_row + coord_t'(8 * dot_size);
        end else begin
            if (code >= CharA && code <= CharZ) begin
                org_x = data[23:8] + pen_x;
                for (j = 0; j < 5; j++) begin
                    dots = LetterDots[code - CharA][j];
                    for (k = 0; k < 7; k++) begin
                        if (dots[k]) begin
                            xl = org_x + coord_t'(j * dot_size);
                            xr = xl + coord_t'(dot_size) - 16'd1;
                            yt = pen_row - coord_t'((k + 1) * dot_size);
                            yb = pen_row - coord_t'(k * dot_size) - 16'd1;
                            if (xl <= xr && yt <= yb && xr < span_x && yb < span_y) begin
                                if (have_held)
                                    squares_due.push_back(held);
                                held      = '{xl, yt, xr, yb, fill, 1'b0};
                                have_held = 1'b1;
                            end
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    squares_due.push_back(held);
                end
            end
            pen_x = pen_x + coord_t'(6 * dot_size);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dot_size = 8'd1;
            fill     = 16'hFFFF;
            span_x   = 16'd240;
            span_y   = 16'd320;
            pen_x    = '0;
            pen_row  = '0;
            squares_due.delete();
        end else begin
            // drain results first: a request accepted on this edge cannot have caused them
            if (m_tvalid && m_tready)
                check_square(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                render_char(s_tdata, s_tuser);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RegScale:  dot_size = pwdata[7:0];
                    RegColor:  fill     = pwdata[15:0];
                    RegWidth:  span_x   = pwdata[15:0];
                    RegHeight: span_y   = pwdata[15:0];
                    default: ;
                endcase
            end
        end
        squares_pending <= squares_due.size();
    end

endmodule

>>> tb/glyph_text_rect_renderer_tb.sv
`timescale 1ns / 100ps
// Testbench top for glyph_text_rect_renderer: drives character requests and register
// writes, throttles the result side, and gives the verdict from the checker's counts.
// Depends on gtr_pkg, glyph_text_rect_renderer and glyph_text_rect_renderer_checker.
module glyph_text_rect_renderer_tb;
    import gtr_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int SettleTicks = 60;
    localparam int TextItems   = 42;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [39:0]      s_tdata;   // char_code[7:0], base_x[23:8], base_y[39:24]
    logic             s_tuser;   // first_of_string
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [79:0]      m_tdata;   // x_left, y_top, x_right, y_bottom, color
    logic             m_tlast;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int     mismatches;
    int     squares_pending;
    int     src_idle_pct;
    int     dst_idle_pct;
    int     cycle_count = 0;
    coord_t cfg_width;
    coord_t cfg_height;

    glyph_text_rect_renderer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    glyph_text_rect_renderer_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .squares_pending (squares_pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("[glyph_text_rect_renderer] ERROR");
            $finish;
        end
    end

    // valid stays high from one request to the next unless an idle cycle drops it
    task automatic send_char(input logic [7:0] code, input logic first,
                             input coord_t bx, input coord_t by);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {by, bx, code};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold requests until every predicted square has come back, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (squares_pending != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_setup(input logic [7:0] sc, input coord_t col,
                              input coord_t w, input coord_t h);
        write_reg(RegScale, {24'd0, sc});
        write_reg(RegColor, {16'd0, col});
        write_reg(RegWidth, {16'd0, w});
        write_reg(RegHeight, {16'd0, h});
        cfg_width  = w;
        cfg_height = h;
    endtask

    task automatic pick_setup(input int mode);
        case (mode)
            0: load_setup(8'($urandom_range(1, 3)), 16'($urandom), 16'd240, 16'd320);
            1: load_setup(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: load_setup(8'($urandom_range(1, 8)), 16'($urandom), 16'($urandom),
                          16'($urandom));
            3: load_setup(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            4: load_setup(8'd1, 16'($urandom), 16'hFFFF, 16'hFFFF);
            default: load_setup(8'($urandom_range(1, 4)), 16'($urandom), 16'd320, 16'd240);
        endcase
    endtask

    // Mostly strings that open with first_of_string and stay on screen, mostly letters;
    // the rest are newlines, stray codes, off-screen origins and strings that continue the old one.
    task automatic run_text(input int count);
        int         sent;
        int         len;
        int         i;
        int         pick;
        coord_t     bx;
        coord_t     by;
        logic [7:0] code;
        logic       first;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            bx  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, cfg_width))
                                              : 16'($urandom);
            by  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, cfg_height))
                                              : 16'($urandom);
            for (i = 0; i < len && sent < count; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    code = CharA + 8'($urandom_range(0, 25));
                else if (pick < 84)
                    code = CharNewline;
                else
                    code = 8'($urandom);
                first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                send_char(code, first, bx, by);
                sent++;
                if (sent == count / 2)
                    drain(0);
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        src_idle_pct = 29;
        dst_idle_pct = 66;
        cfg_width    = 16'd240;
        cfg_height   = 16'd320;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // power-on setup: letters, empty first column, newline, codes around A..Z
        send_char(CharA, 1'b1, 16'd0, 16'd20);
        send_char(CharZ, 1'b0, 16'd0, 16'd20);
        send_char(CharA + 8'd8, 1'b0, 16'd0, 16'd20);
        send_char(CharNewline, 1'b0, 16'd0, 16'd20);
        send_char(CharA + 8'd12, 1'b0, 16'd0, 16'd20);
        send_char(8'd0, 1'b0, 16'd0, 16'd20);
        send_char(8'hFF, 1'b0, 16'd0, 16'd20);
        send_char(CharA - 8'd1, 1'b0, 16'd0, 16'd20);
        send_char(CharZ + 8'd1, 1'b0, 16'd0, 16'd20);
        send_char(CharA + 8'd22, 1'b0, 16'd0, 16'd20);
        // x wraps past the top of the coordinate range
        send_char(CharA, 1'b1, 16'hFFFF, 16'd320);
        // baseline at zero and at the top: every square dropped
        send_char(CharA + 8'd1, 1'b1, 16'd235, 16'd0);
        send_char(CharA + 8'd7, 1'b1, 16'd0, 16'hFFFF);
        send_char(CharNewline, 1'b1, 16'd5, 16'd100);
        send_char(CharA + 8'd16, 1'b0, 16'd5, 16'd100);

        // zero dot size: every square dropped
        drain(SettleTicks);
        load_setup(8'd0, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_char(CharA, 1'b1, 16'd0, 16'd0);
        send_char(CharNewline, 1'b0, 16'd0, 16'd0);
        send_char(CharA + 8'd23, 1'b0, 16'd0, 16'd0);

        // empty screen
        drain(SettleTicks);
        load_setup(8'd3, 16'hFFFF, 16'd0, 16'd0);
        send_char(CharA + 8'd14, 1'b1, 16'd10, 16'd40);
        send_char(CharNewline, 1'b0, 16'd10, 16'd40);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 66 : 0;
            dst_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 29 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                drain(SettleTicks);
                pick_setup(ph * 2 + sub);
                run_text(TextItems);
            end
        end

        drain(SettleTicks);
        if (mismatches == 0 && squares_pending == 0)
            $display("[glyph_text_rect_renderer] OK");
        else
            $display("[glyph_text_rect_renderer] ERROR");
        $finish;
    end

endmodule
